/* rtl/fbpfl_pkg.sv */
// Shared types and constants of the fixed block pool free list.
package fbpfl_pkg;

    localparam int CNT_W = 11;
    localparam int IDX_W = 10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_NONE    = 2'd3
    } fbp_status_t;

    typedef enum logic {
        S_IDLE,
        S_POP
    } fbp_state_t;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] free_index;
    } fbp_req_t;

    typedef struct packed {
        fbp_status_t      status;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] free_count;
    } fbp_rsp_t;

endpackage

/* rtl/fixed_block_pool_free_list.sv */
// Top level of the fixed block pool free list.
//
//  Channel   Direction  Handshake           Contents
//  in        request    in_valid/in_ready   cmd, free_index
//  out       result     out_valid/out_ready status, block_index, free_count
//  cfg       write      cfg_we              blocks_in_use
//
// An allocate that leaves blocks free also passes through S_POP, because the new
// head is read from the link RAM through its registered read port.
// Reset clears the head, the counters and the output valid flag; the link RAM
// is not cleared.
// A result waiting in the output register blocks a new request only when it
// is not taken in the same cycle.
module fixed_block_pool_free_list
    import fbpfl_pkg::*;
#(
    parameter int POOL_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fbp_req_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output fbp_rsp_t         out_data,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int XW = (AW > CNT_W) ? AW : CNT_W;
    localparam logic [CNT_W-1:0] BIU_MAX = CNT_W'((POOL_DEPTH > 2047) ? 2047 : POOL_DEPTH);
    localparam logic [CNT_W-1:0] BIU_RST = CNT_W'((POOL_DEPTH > 1024) ? 1024 : POOL_DEPTH);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    fbp_state_t       state_reg, state_next;
    logic [CNT_W-1:0] biu_reg, biu_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] thr_reg, thr_next;
    logic             fwd_reg, fwd_next;
    logic             past_end_reg, past_end_next;
    logic             out_valid_reg, out_valid_next;
    fbp_rsp_t         out_data_reg, out_data_next;

    logic             in_fire;
    logic             thr_do;
    logic [CNT_W-1:0] free_now, used_inc, free_inc, used_dec, free_dec;
    logic             ram_we, ram_re;
    logic [CNT_W-1:0] ram_wdata, ram_rdata;
    logic [XW-1:0]    waddr_x, raddr_x;

    fbpfl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_x[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign thr_do   = thr_reg < biu_reg;
    assign free_now = (used_reg < biu_reg) ? biu_reg - used_reg : '0;
    assign used_inc = used_reg + ONE;
    assign free_inc = (used_inc < biu_reg) ? biu_reg - used_inc : '0;
    assign used_dec = used_reg - ONE;
    assign free_dec = (used_dec < biu_reg) ? biu_reg - used_dec : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            biu_reg       <= BIU_RST;
            head_reg      <= '0;
            used_reg      <= '0;
            thr_reg       <= '0;
            fwd_reg       <= 1'b0;
            past_end_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            biu_reg       <= biu_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            thr_reg       <= thr_next;
            fwd_reg       <= fwd_next;
            past_end_reg  <= past_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        biu_next = biu_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                biu_next = ONE;
            end
            else if (cfg_wdata > BIU_MAX)
            begin
                biu_next = BIU_MAX;
            end
            else
            begin
                biu_next = cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        used_next      = used_reg;
        thr_next       = thr_reg;
        fwd_next       = fwd_reg;
        past_end_next  = past_end_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = '0;
        waddr_x        = '0;
        raddr_x        = XW'(head_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = ST_OK;
                    out_data_next.block_index = '0;
                    out_data_next.free_count  = free_now;
                    case (in_data.cmd)
                        CMD_ALLOC:
                        begin
                            if (thr_do)
                            begin
                                ram_we    = 1'b1;
                                waddr_x   = XW'(thr_reg);
                                ram_wdata = thr_reg + ONE;
                                thr_next  = thr_reg + ONE;
                            end
                            if (free_now != '0)
                            begin
                                out_data_next.block_index = head_reg[IDX_W-1:0];
                                out_data_next.free_count  = free_inc;
                                used_next                 = used_inc;
                                if (free_inc != '0)
                                begin
                                    ram_re        = 1'b1;
                                    fwd_next      = thr_do && (thr_reg == head_reg);
                                    past_end_next = 32'(head_reg) >= 32'(POOL_DEPTH);
                                    state_next    = S_POP;
                                end
                            end
                            else
                            begin
                                out_data_next.status = ST_FULL;
                            end
                        end
                        default:
                        begin
                            if (in_data.free_index >= biu_reg)
                            begin
                                out_data_next.status = ST_OUTSIDE;
                            end
                            else if (used_reg == '0)
                            begin
                                out_data_next.status = ST_NONE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                waddr_x   = XW'(in_data.free_index);
                                ram_wdata = (free_now == '0) ? biu_reg : head_reg;
                                head_next = in_data.free_index;
                                used_next = used_dec;
                                out_data_next.free_count = free_dec;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // The link just threaded is still in flight when the head is that block.
                // A head beyond the end of the store has a link of zero.
                head_next  = fwd_reg ? thr_reg : (past_end_reg ? '0 : ram_rdata);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_data.cmd == CMD_ALLOC) && (free_now != '0) && (free_inc != '0)
        |=> state_reg == S_POP)
        else $error("allocate leaving blocks free did not fetch the next head");

    a_no_request_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> !in_fire)
        else $error("request accepted while the head fetch is pending");

    a_read_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (in_data.cmd == CMD_ALLOC) && in_fire)
        else $error("link read issued outside an allocate");

    a_thread_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> thr_reg >= $past(thr_reg))
        else $error("threaded count went backwards");

endmodule

/* rtl/fbpfl_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module fbpfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* verif/tb.sv */
// Self-checking testbench of the fixed block pool free list, driven by directed and random requests.
`timescale 1ns / 100ps

module tb;
    import fbpfl_pkg::*;

    localparam int DEPTH = 1024;
    localparam int PHASES = 12;
    localparam int SIZE_PLAN [PHASES] = '{2047, 1500, 3, 0, 17, 2, 64, 1, 9, 1024, 33, 4};
    localparam bit KEEP_PLAN [PHASES] = '{1, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

    class pool_scoreboard;
        logic [CNT_W-1:0] link_mem [DEPTH];
        bit               link_set [DEPTH];
        int unsigned      head = 0;
        int unsigned      used = 0;
        int unsigned      threaded = 0;
        int unsigned      pool_size = DEPTH;
        int unsigned      failures = 0;
        fbp_rsp_t         expected_rsp [$];
        int unsigned      held [$];

        function int unsigned free_blocks();
            return (used < pool_size) ? pool_size - used : 0;
        endfunction

        function void set_size(int unsigned value);
            int unsigned v;
            v = value & 32'h7FF;
            if (v == 0)
                v = 1;
            if (v > DEPTH)
                v = DEPTH;
            pool_size = v;
        endfunction

        function int unsigned link_get(int unsigned a);
            return (a < DEPTH) ? int'(link_mem[a]) : 0;
        endfunction

        function void link_put(int unsigned a, int unsigned v);
            if (a < DEPTH)
            begin
                link_mem[a] = v[CNT_W-1:0];
                link_set[a] = 1'b1;
            end
        endfunction

        // An allocate is safe when the pop that follows it reads only a link already written.
        function bit alloc_safe();
            if (free_blocks() == 0 || used + 1 >= pool_size)
                return 1'b1;
            return head >= DEPTH || link_set[head]
                || (threaded < pool_size && head == threaded);
        endfunction

        function void note_request(fbp_req_t r);
            fbp_rsp_t e;
            int       i;
            e.status = ST_OK;
            e.block_index = '0;
            if (r.cmd == CMD_ALLOC)
            begin
                if (threaded < pool_size)
                begin
                    link_put(threaded, threaded + 1);
                    threaded = (threaded + 1) & 32'h7FF;
                end
                if (free_blocks() != 0)
                begin
                    e.block_index = head[IDX_W-1:0];
                    held.push_back(head & 32'h3FF);
                    used = (used + 1) & 32'h7FF;
                    if (free_blocks() != 0)
                        head = link_get(head);
                end
                else
                    e.status = ST_FULL;
            end
            else if (r.free_index >= pool_size)
                e.status = ST_OUTSIDE;
            else if (used == 0)
                e.status = ST_NONE;
            else
            begin
                link_put(r.free_index, (free_blocks() == 0) ? pool_size : head);
                head = r.free_index;
                used = used - 1;
                for (i = 0; i < held.size(); i++)
                begin
                    if (held[i] == r.free_index)
                    begin
                        held.delete(i);
                        break;
                    end
                end
            end
            e.free_count = CNT_W'(free_blocks());
            expected_rsp.push_back(e);
        endfunction

        function void report(string msg);
            if (failures < 10)
                $display("%s", msg);
            failures++;
        endfunction

        function void check_result(fbp_rsp_t got);
            fbp_rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                report($sformatf("unexpected result: status %0d block %0d free %0d",
                                 got.status, got.block_index, got.free_count));
                return;
            end
            e = expected_rsp.pop_front();
            if (got.status !== e.status || got.block_index !== e.block_index
                || got.free_count !== e.free_count)
                report($sformatf({"result mismatch: expected status %0d block %0d free %0d,",
                                  " got status %0d block %0d free %0d"},
                                 e.status, e.block_index, e.free_count,
                                 got.status, got.block_index, got.free_count));
        endfunction
    endclass

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    fbp_req_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    fbp_rsp_t         out_data;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    bit               quiet = 1'b0;
    pool_scoreboard   sb;

    fixed_block_pool_free_list #(
        .POOL_DEPTH(DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send(logic op, logic [CNT_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= '{cmd: op, free_index: idx};
        do @(posedge clk); while (!in_ready);
        sb.note_request(in_data);
    endtask

    task automatic random_request(int alloc_pct);
        int               r;
        logic             op;
        logic [CNT_W-1:0] idx;
        r = $urandom_range(0, 99);
        idx = CNT_W'($urandom_range(0, 2047));
        op = CMD_ALLOC;
        if (r >= alloc_pct)
        begin
            op = CMD_FREE;
            r = $urandom_range(0, 99);
            if (r < 60 && sb.held.size() > 0)
                idx = CNT_W'(sb.held[$urandom_range(0, sb.held.size() - 1)]);
            else if (r < 85)
                idx = CNT_W'($urandom_range(0, sb.pool_size - 1));
        end
        if (op == CMD_ALLOC && !sb.alloc_safe())
            op = CMD_FREE;
        send(op, idx);
    endtask

    task automatic drain();
        logic [CNT_W-1:0] idx;
        while (sb.used != 0)
        begin
            if (sb.held.size() > 0 && sb.held[0] < sb.pool_size)
                idx = CNT_W'(sb.held[0]);
            else
                idx = CNT_W'($urandom_range(0, sb.pool_size - 1));
            send(CMD_FREE, idx);
        end
    endtask

    task automatic settle();
        int n;
        @(negedge clk);
        in_valid <= 1'b0;
        n = 0;
        while (sb.expected_rsp.size() != 0 && n < 5000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_size(logic [CNT_W-1:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_size(v);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int count;
        sb = new;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Frees before anything is allocated, and frees beyond the pool.
        send(CMD_FREE, 11'd0);
        send(CMD_FREE, 11'd2047);
        send(CMD_FREE, 11'd1024);
        repeat (3) send(CMD_ALLOC, 11'd2047);
        send(CMD_FREE, 11'd1);
        send(CMD_ALLOC, 11'd0);
        send(CMD_FREE, 11'd1023);
        send(CMD_ALLOC, 11'd0);
        drain();

        // A size of zero is taken as one block, so the second allocate finds the pool full.
        write_size(11'd0);
        repeat (2) send(CMD_ALLOC, 11'd0);
        send(CMD_FREE, 11'd1);
        send(CMD_FREE, 11'd0);
        send(CMD_FREE, 11'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (!KEEP_PLAN[p])
                drain();
            write_size(CNT_W'(SIZE_PLAN[p]));
            quiet = ($urandom_range(0, 3) == 0);
            count = (sb.pool_size >= 512) ? 120 : $urandom_range(25, 40);
            for (int k = 0; k < count; k++)
                random_request((sb.pool_size >= 512) ? 70 : 60);
        end

        settle();
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.expected_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
